// File: design/assert_macros.svh
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cmm_pkg.sv
// Package: types, constants and helpers of the complex matrix multiply unit
`timescale 1ns / 1ps
package cmm_pkg;

   localparam int CMM_MAX_DIM   = 8;
   localparam int CMM_ELEM_BITS = 16;
   localparam int CMM_DIM_BITS  = 4;
   localparam int CMM_IDX_BITS  = 3;
   localparam int CMM_OUT_BITS  = 37;
   localparam logic [CMM_DIM_BITS-1:0] CMM_DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      ACT_LOAD_A   = 2'd0,
      ACT_LOAD_B   = 2'd1,
      ACT_MULTIPLY = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic first;
   } cmm_tag_type;

   function automatic logic [CMM_DIM_BITS-1:0] limit_dim(
      input logic [CMM_DIM_BITS-1:0] d,
      input logic [CMM_DIM_BITS-1:0] max_d
   );
      logic [CMM_DIM_BITS-1:0] res;
      res = d;
      if (d == '0) begin
         res = 4'd1;
      end else if (d > max_d) begin
         res = max_d;
      end
      return res;
   endfunction

endpackage

// File: design/cmm_mac.sv
// Pipelined complex multiply-accumulate unit shared by all product terms
`timescale 1ns / 1ps
module cmm_mac
   import cmm_pkg::*;
#(
   parameter int ELEM_BITS = CMM_ELEM_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmm_tag_type                    tag_in,
   input  logic signed [ELEM_BITS-1:0]    a_re,
   input  logic signed [ELEM_BITS-1:0]    a_im,
   input  logic signed [ELEM_BITS-1:0]    b_re,
   input  logic signed [ELEM_BITS-1:0]    b_im,
   output logic signed [CMM_OUT_BITS-1:0] acc_re,
   output logic signed [CMM_OUT_BITS-1:0] acc_im,
   output logic                           busy
);

   localparam int PROD_W = 2 * ELEM_BITS;
   localparam int TERM_W = PROD_W + 1;

   cmm_tag_type                    s1_tag_ff;
   cmm_tag_type                    s2_tag_ff;
   logic signed [PROD_W-1:0]       p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [TERM_W-1:0]       t_re_ff, t_im_ff;
   logic signed [CMM_OUT_BITS-1:0] acc_re_ff, acc_im_ff;
   logic signed [CMM_OUT_BITS-1:0] t_re_ext, t_im_ext;

   assign t_re_ext = CMM_OUT_BITS'(t_re_ff);
   assign t_im_ext = CMM_OUT_BITS'(t_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= a_re * b_re;
      p_ii_ff <= a_im * b_im;
      p_ri_ff <= a_re * b_im;
      p_ir_ff <= a_im * b_re;
      t_re_ff <= TERM_W'(p_rr_ff) - TERM_W'(p_ii_ff);
      t_im_ff <= TERM_W'(p_ri_ff) + TERM_W'(p_ir_ff);
      if (s2_tag_ff.valid) begin
         if (s2_tag_ff.first) begin
            acc_re_ff <= t_re_ext;
            acc_im_ff <= t_im_ext;
         end else begin
            acc_re_ff <= acc_re_ff + t_re_ext;
            acc_im_ff <= acc_im_ff + t_im_ext;
         end
      end
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
   assign busy   = s1_tag_ff.valid | s2_tag_ff.valid;

endmodule

// File: design/complex_matrix_multiply_unit.sv
// Top level: complex matrix multiply unit with element stores and sequencer
//
// Usage:
//   req channel: action 0 or 1 writes one complex element of A or B at
//   (row, col); elements outside the store are dropped. Action 2 multiplies.
//   Loads give no transaction on rsp.
//   csr channel: writes a_rows, a_cols, b_rows, b_cols (index 0 to 3); it is
//   always ready. Write it only while the unit is idle.
//   rsp channel: one transaction per product element in row-major order,
//   last set on the final one; an inner-dimension mismatch gives a single
//   transaction with mismatch and last set and zero payload.
//   Timing: one complex multiply-accumulate per cycle in a shared unit while
//   the k terms of a product element issue (k the inner dimension, up to 8);
//   they pass the memory read stage and the three-stage multiply-accumulate,
//   and the next element issues only once they have drained. The unit holds
//   req_stall high for the whole of a multiply.
//   Reset: dimensions return to 8, rsp goes empty; stores hold no defined
//   contents until written.
//   rsp_stall holds the finished element in the output register; the
//   sequencer waits before loading the next one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_matrix_multiply_unit
   import cmm_pkg::*;
#(
   parameter int MAX_DIM   = CMM_MAX_DIM,
   parameter int ELEM_BITS = CMM_ELEM_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [CMM_IDX_BITS-1:0]        req_row,
   input  logic [CMM_IDX_BITS-1:0]        req_col,
   input  logic signed [ELEM_BITS-1:0]    req_in_real,
   input  logic signed [ELEM_BITS-1:0]    req_in_imag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [CMM_IDX_BITS-1:0]        rsp_out_row,
   output logic [CMM_IDX_BITS-1:0]        rsp_out_col,
   output logic signed [CMM_OUT_BITS-1:0] rsp_out_real,
   output logic signed [CMM_OUT_BITS-1:0] rsp_out_imag,
   output logic                           rsp_mismatch,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [CMM_DIM_BITS-1:0]        csr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIN_W  = 2 * CMM_IDX_BITS;
   localparam int WORD_W = 2 * ELEM_BITS;
   localparam logic [CMM_DIM_BITS-1:0] MAX_D = CMM_DIM_BITS'(MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ERROR
   } state_type;

   state_type                      state_ff;
   logic [CMM_IDX_BITS-1:0]        r_ff, c_ff, i_ff;
   logic [CMM_DIM_BITS-1:0]        a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   cmm_tag_type                    rd_tag_ff;
   logic [WORD_W-1:0]              a_rd_ff, b_rd_ff;
   logic [WORD_W-1:0]              a_mem [DEPTH];
   logic [WORD_W-1:0]              b_mem [DEPTH];
   logic                           rsp_valid_ff;
   logic [CMM_IDX_BITS-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [CMM_OUT_BITS-1:0] rsp_real_ff, rsp_imag_ff;
   logic                           rsp_mismatch_ff, rsp_last_ff;

   logic [CMM_DIM_BITS-1:0]        m_lim, k_lim, kb_lim, n_lim;
   logic                           req_take, wr_in_range, wr_a, wr_b;
   logic [LIN_W-1:0]               wr_lin, a_lin, b_lin;
   logic [ADDR_W-1:0]              wr_addr, a_raddr, b_raddr;
   logic                           last_i, last_c, last_r, rsp_free, pipe_busy;
   logic signed [CMM_OUT_BITS-1:0] acc_re, acc_im;
   logic                           mac_busy;

   assign m_lim  = limit_dim(a_rows_ff, MAX_D);
   assign k_lim  = limit_dim(a_cols_ff, MAX_D);
   assign kb_lim = limit_dim(b_rows_ff, MAX_D);
   assign n_lim  = limit_dim(b_cols_ff, MAX_D);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign wr_in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign wr_lin  = LIN_W'(req_row) * LIN_W'(MAX_DIM) + LIN_W'(req_col);
   assign wr_addr = ADDR_W'(wr_lin);
   assign wr_a    = req_take && wr_in_range && (req_action == ACT_LOAD_A);
   assign wr_b    = req_take && wr_in_range && (req_action == ACT_LOAD_B);

   assign a_lin   = LIN_W'(r_ff) * LIN_W'(MAX_DIM) + LIN_W'(i_ff);
   assign b_lin   = LIN_W'(i_ff) * LIN_W'(MAX_DIM) + LIN_W'(c_ff);
   assign a_raddr = ADDR_W'(a_lin);
   assign b_raddr = ADDR_W'(b_lin);

   assign last_i    = ((CMM_DIM_BITS'(i_ff) + 4'd1) == k_lim);
   assign last_c    = ((CMM_DIM_BITS'(c_ff) + 4'd1) == n_lim);
   assign last_r    = ((CMM_DIM_BITS'(r_ff) + 4'd1) == m_lim);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pipe_busy = rd_tag_ff.valid | mac_busy;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_mem[wr_addr] <= {req_in_real, req_in_imag};
      end
      if (wr_b) begin
         b_mem[wr_addr] <= {req_in_real, req_in_imag};
      end
      a_rd_ff <= a_mem[a_raddr];
      b_rd_ff <= b_mem[b_raddr];
   end

   cmm_mac #(
      .ELEM_BITS(ELEM_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag_in (rd_tag_ff),
      .a_re   (a_rd_ff[WORD_W-1:ELEM_BITS]),
      .a_im   (a_rd_ff[ELEM_BITS-1:0]),
      .b_re   (b_rd_ff[WORD_W-1:ELEM_BITS]),
      .b_im   (b_rd_ff[ELEM_BITS-1:0]),
      .acc_re (acc_re),
      .acc_im (acc_im),
      .busy   (mac_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_tag_ff    <= '0;
         a_rows_ff    <= CMM_DIM_RESET;
         a_cols_ff    <= CMM_DIM_RESET;
         b_rows_ff    <= CMM_DIM_RESET;
         b_cols_ff    <= CMM_DIM_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_A_ROWS: a_rows_ff <= csr_data;
               CSR_A_COLS: a_cols_ff <= csr_data;
               CSR_B_ROWS: b_rows_ff <= csr_data;
               CSR_B_COLS: b_cols_ff <= csr_data;
               default:    a_rows_ff <= a_rows_ff;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_tag_ff.valid <= (state_ff == ST_ISSUE);
         rd_tag_ff.first <= (i_ff == '0);
         case (state_ff)
            ST_IDLE: begin
               if (req_take && (req_action == ACT_MULTIPLY)) begin
                  r_ff <= '0;
                  c_ff <= '0;
                  i_ff <= '0;
                  if (k_lim != kb_lim) begin
                     state_ff <= ST_ERROR;
                  end else begin
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: begin
               if (last_i) begin
                  i_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  i_ff <= i_ff + 3'd1;
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy && rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_row_ff      <= r_ff;
                  rsp_col_ff      <= c_ff;
                  rsp_real_ff     <= acc_re;
                  rsp_imag_ff     <= acc_im;
                  rsp_mismatch_ff <= 1'b0;
                  rsp_last_ff     <= last_r && last_c;
                  if (last_c) begin
                     c_ff <= '0;
                     if (last_r) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        r_ff     <= r_ff + 3'd1;
                        state_ff <= ST_ISSUE;
                     end
                  end else begin
                     c_ff     <= c_ff + 3'd1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ERROR: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_row_ff      <= '0;
                  rsp_col_ff      <= '0;
                  rsp_real_ff     <= '0;
                  rsp_imag_ff     <= '0;
                  rsp_mismatch_ff <= 1'b1;
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_out_real = rsp_real_ff;
   assign rsp_out_imag = rsp_imag_ff;
   assign rsp_mismatch = rsp_mismatch_ff;
   assign rsp_last     = rsp_last_ff;

   `ASSERT_IMPL(a_pipe_in_multiply, clock, reset, pipe_busy, (state_ff == ST_ISSUE || state_ff == ST_DRAIN), "pipeline busy outside a multiply")
   `ASSERT_IMPL(a_issue_in_range, clock, reset, (state_ff == ST_ISSUE), (CMM_DIM_BITS'(i_ff) < k_lim), "term index beyond inner dimension")
   `ASSERT_IMPL(a_mismatch_last, clock, reset, (rsp_valid_ff && rsp_mismatch_ff), rsp_last_ff, "mismatch transaction without last")
   `ASSERT_NEXT(a_drain_loads, clock, reset, (state_ff == ST_DRAIN && !pipe_busy && rsp_free), (rsp_valid_ff && !rsp_mismatch_ff), "drained element not loaded")

endmodule
